FILE: rtl/gdd_pkg.sv
// Types, constants and calendar tables for the Gregorian date difference unit.
package gdd_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned CountW = 22;
  localparam int unsigned DnumW  = 23;  // day number of any 14-bit year fits here

  localparam logic [YearW-1:0]  YEAR_MIN = 14'd1582;
  localparam logic [YearW-1:0]  YEAR_MAX = 14'd9999;
  localparam logic [MonthW-1:0] MONTH_JAN = 4'd1;
  localparam logic [MonthW-1:0] MONTH_FEB = 4'd2;
  localparam logic [MonthW-1:0] MONTH_DEC = 4'd12;

  // floor(x / 25) == (x * 1311) >> 15 for x below 4681
  localparam logic [10:0] RECIP_25  = 11'd1311;
  localparam int unsigned RECIP_SHR = 15;

  typedef struct packed {
    logic [DayW-1:0]   first_day;
    logic [MonthW-1:0] first_month;
    logic [YearW-1:0]  first_year;
    logic [DayW-1:0]   second_day;
    logic [MonthW-1:0] second_month;
    logic [YearW-1:0]  second_year;
  } gdd_req_t;

  typedef struct packed {
    logic [CountW-1:0] day_count;
    logic              date_invalid;
  } gdd_rsp_t;

  typedef struct packed {
    logic             valid;
    logic [DnumW-1:0] dnum;
  } gdd_date_t;

  function automatic logic [DayW-1:0] days_in_month(input logic [MonthW-1:0] month,
                                                    input logic leap);
    logic [DayW-1:0] len;
    case (month)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Days before the first of the month, in a year that starts on March 1.
  function automatic logic [8:0] month_offset(input logic [MonthW-1:0] month);
    logic [8:0] offs;
    case (month)
      4'd3:    offs = 9'd0;
      4'd4:    offs = 9'd31;
      4'd5:    offs = 9'd61;
      4'd6:    offs = 9'd92;
      4'd7:    offs = 9'd122;
      4'd8:    offs = 9'd153;
      4'd9:    offs = 9'd184;
      4'd10:   offs = 9'd214;
      4'd11:   offs = 9'd245;
      4'd12:   offs = 9'd275;
      4'd1:    offs = 9'd306;
      4'd2:    offs = 9'd337;
      default: offs = 9'd0;
    endcase
    return offs;
  endfunction

endpackage

FILE: rtl/gregorian_date_difference_unit.sv
// Top level of the Gregorian date difference unit.
//
// Takes two Gregorian dates and returns the absolute number of days between
// them, or date_invalid with a zero count when either date is out of range
// (year outside 1582..9999, month outside 1..12, day outside the month).
// A pair is taken on every clock edge where start_i is high; busy_o is
// always low, so a new pair may follow every cycle. Each result appears on
// rsp_o for exactly one cycle with done_o high, once the pair has passed
// the input register and then the result register.
// Results come out in the order the pairs went in. The receiver cannot stall
// the unit, so it must take every transfer in the cycle it is shown.
module gregorian_date_difference_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  gdd_pkg::gdd_req_t req_i,
  output logic              busy_o,
  output logic              done_o,
  output gdd_pkg::gdd_rsp_t rsp_o
);
  import gdd_pkg::*;

  logic       in_vld_q;
  gdd_req_t   req_q;
  logic       done_q;
  gdd_rsp_t   rsp_q;
  gdd_rsp_t   rsp_d;

  gdd_date_t  first_date;
  gdd_date_t  second_date;
  logic [DnumW-1:0] diff;

  // input register: control reset, payload without reset, loaded when start_i is high
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      req_q <= req_i;
    end
  end

  gdd_date_eval u_first (
    .day_i   (req_q.first_day),
    .month_i (req_q.first_month),
    .year_i  (req_q.first_year),
    .date_o  (first_date)
  );

  gdd_date_eval u_second (
    .day_i   (req_q.second_day),
    .month_i (req_q.second_month),
    .year_i  (req_q.second_year),
    .date_o  (second_date)
  );

  // absolute difference of the two day numbers
  assign diff = (first_date.dnum > second_date.dnum) ? first_date.dnum - second_date.dnum
                                                     : second_date.dnum - first_date.dnum;

  always_comb begin
    if (first_date.valid && second_date.valid) begin
      rsp_d.day_count    = diff[CountW-1:0];
      rsp_d.date_invalid = 1'b0;
    end else begin
      rsp_d.day_count    = '0;
      rsp_d.date_invalid = 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign busy_o = 1'b0;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

FILE: rtl/gdd_date_eval.sv
// Validity check and March-based day number of one calendar date.
module gdd_date_eval (
  input  logic [gdd_pkg::DayW-1:0]   day_i,
  input  logic [gdd_pkg::MonthW-1:0] month_i,
  input  logic [gdd_pkg::YearW-1:0]  year_i,
  output gdd_pkg::gdd_date_t         date_o
);
  import gdd_pkg::*;

  logic [YearW-3:0]   y_quarter;
  logic [22:0]        y_prod;
  logic [7:0]         y_cent;
  logic [YearW-1:0]   y_cent_x100;
  logic               div100;
  logic               leap;
  logic               year_ok;
  logic               month_ok;
  logic               day_ok;

  logic [YearW-1:0]   yy;
  logic [YearW-3:0]   yy_quarter;
  logic [22:0]        yy_prod;
  logic [7:0]         yy_cent;
  logic [DnumW-1:0]   yy_days;

  // leap year: century test through a reciprocal of 25 on year/4
  assign y_quarter   = year_i[YearW-1:2];
  assign y_prod      = {11'd0, y_quarter} * {12'd0, RECIP_25};
  assign y_cent      = y_prod[RECIP_SHR +: 8];
  assign y_cent_x100 = {6'd0, y_cent} * 14'd100;
  assign div100      = (y_cent_x100 == year_i);
  assign leap        = ((year_i[1:0] == 2'd0) && !div100) || (div100 && (y_cent[1:0] == 2'd0));

  always_comb begin
    year_ok  = year_i inside {[YEAR_MIN:YEAR_MAX]};
    month_ok = month_i inside {[MONTH_JAN:MONTH_DEC]};
    day_ok   = (day_i != '0) && (day_i <= days_in_month(month_i, leap));
  end

  // January and February count with the previous year
  assign yy         = (month_i <= MONTH_FEB) ? year_i - 14'd1 : year_i;
  assign yy_quarter = yy[YearW-1:2];
  assign yy_prod    = {11'd0, yy_quarter} * {12'd0, RECIP_25};
  assign yy_cent    = yy_prod[RECIP_SHR +: 8];
  assign yy_days    = {9'd0, yy} * 23'd365;

  assign date_o.valid = year_ok && month_ok && day_ok;
  assign date_o.dnum  = yy_days
                      + {11'd0, yy_quarter}
                      - {15'd0, yy_cent}
                      + {17'd0, yy_cent[7:2]}
                      + {14'd0, month_offset(month_i)}
                      + {18'd0, day_i};

endmodule

FILE: sim/gregorian_date_difference_unit_test.sv
// Self-checking testbench for the Gregorian date difference unit.
`timescale 1ns / 1ps

module gregorian_date_difference_unit_test;
  import gdd_pkg::*;

  localparam int unsigned RandomPairs = 1030;
  localparam int unsigned IdleLimit   = 500;  // cycles with no transfer before giving up
  localparam int unsigned TailCycles  = 10;

  typedef struct {
    gdd_req_t    pair;
    int unsigned gap;    // idle cycles before this pair is offered
    bit          drain;  // hold until every outstanding result is back
  } pair_item_t;

  logic     clk_i;
  logic     rst_ni;
  logic     start_i = 1'b0;
  gdd_req_t req_i   = '0;
  logic     busy_o;
  logic     done_o;
  gdd_rsp_t rsp_o;

  pair_item_t  pair_q[$];
  gdd_rsp_t    span_q[$];
  logic        all_drained;
  int unsigned idle_cycles;
  int unsigned mismatch_cnt;
  int unsigned pairs_taken;
  int unsigned spans_checked;
  int unsigned invalid_seen;
  int unsigned widest_span;

  gregorian_date_difference_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------
  function automatic bit is_leap(int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic int unsigned month_days(int unsigned mo, int unsigned yr);
    if (mo == MONTH_FEB) return is_leap(yr) ? 29 : 28;
    if (mo == 4 || mo == 6 || mo == 9 || mo == 11) return 30;
    return 31;
  endfunction

  function automatic bit date_ok(int unsigned dd, int unsigned mo, int unsigned yr);
    if (yr < YEAR_MIN || yr > YEAR_MAX) return 1'b0;
    if (mo < MONTH_JAN || mo > MONTH_DEC) return 1'b0;
    return (dd >= 1) && (dd <= month_days(mo, yr));
  endfunction

  // Days since a fixed origin, counted with January-based years.
  function automatic int unsigned day_ordinal(int unsigned dd, int unsigned mo,
                                               int unsigned yr);
    int unsigned prior;
    int unsigned total;
    prior = yr - 1;
    total = 365 * prior + prior / 4 - prior / 100 + prior / 400;
    for (int unsigned m = MONTH_JAN; m < mo; m++) total += month_days(m, yr);
    return total + dd;
  endfunction

  function automatic gdd_rsp_t predict_span(gdd_req_t p);
    gdd_rsp_t    r;
    int unsigned a;
    int unsigned b;
    r = '0;
    if (!date_ok(p.first_day, p.first_month, p.first_year) ||
        !date_ok(p.second_day, p.second_month, p.second_year)) begin
      r.date_invalid = 1'b1;
      return r;
    end
    a = day_ordinal(p.first_day, p.first_month, p.first_year);
    b = day_ordinal(p.second_day, p.second_month, p.second_year);
    r.day_count = CountW'((a > b) ? a - b : b - a);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic gdd_req_t make_pair(int unsigned d1, int unsigned m1, int unsigned y1,
                                         int unsigned d2, int unsigned m2, int unsigned y2);
    gdd_req_t p;
    p.first_day    = d1[DayW-1:0];
    p.first_month  = m1[MonthW-1:0];
    p.first_year   = y1[YearW-1:0];
    p.second_day   = d2[DayW-1:0];
    p.second_month = m2[MonthW-1:0];
    p.second_year  = y2[YearW-1:0];
    return p;
  endfunction

  task automatic queue_pair(gdd_req_t p, int unsigned gap, bit drain);
    pair_item_t it;
    it.pair  = p;
    it.gap   = gap;
    it.drain = drain;
    pair_q.push_back(it);
  endtask

  // Mostly well-formed dates, with day edges, out-of-range years and raw noise.
  task automatic make_date(output logic [DayW-1:0] dd, output logic [MonthW-1:0] mo,
                           output logic [YearW-1:0] yr);
    int unsigned pick;
    int unsigned len;
    int unsigned y;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      dd = DayW'($urandom);
      mo = MonthW'($urandom);
      yr = YearW'($urandom);
    end else begin
      case ($urandom_range(0, 5))
        0:       y = $urandom_range(YEAR_MIN, 1700);
        1:       y = $urandom_range(9900, YEAR_MAX);
        2:       y = 4 * $urandom_range(396, 2499);
        default: y = $urandom_range(YEAR_MIN, YEAR_MAX);
      endcase
      if (pick < 15) y = $urandom_range(0, 1) ? $urandom_range(1500, YEAR_MIN - 1)
                                              : $urandom_range(YEAR_MAX + 1, 16383);
      mo  = MonthW'($urandom_range(MONTH_JAN, MONTH_DEC));
      yr  = YearW'(y);
      len = month_days(mo, y);
      if (pick < 85) begin
        dd = DayW'($urandom_range(1, len));
      end else begin
        case ($urandom_range(0, 3))
          0:       dd = '0;
          1:       dd = DayW'(len);
          2:       dd = DayW'(len + 1);
          default: dd = DayW'(31);
        endcase
      end
    end
  endtask

  function automatic int unsigned pick_gap(bit no_idle);
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers pairs from pair_q, honoring gaps and drain requests
  // ---------------------------------------------------------------------------
  pair_item_t  stage;
  logic        staged;
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i  <= 1'b0;
      req_i    <= '0;
      staged   = 1'b0;
      gap_left = 0;
    end else if (!(start_i && busy_o)) begin
      if (!staged && pair_q.size() != 0) begin
        stage    = pair_q.pop_front();
        gap_left = stage.gap;
        staged   = 1'b1;
      end
      // A drain waits until start_i is low so all_drained covers the last transfer.
      if (staged && gap_left == 0 && (!stage.drain || (!start_i && all_drained))) begin
        start_i <= 1'b1;
        req_i   <= stage.pair;
        staged  = 1'b0;
      end else begin
        start_i <= 1'b0;
        if (staged && gap_left != 0) gap_left--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on each input transfer, checks each result, watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    gdd_rsp_t want;
    if (!rst_ni) begin
      all_drained <= 1'b1;
      idle_cycles <= 0;
    end else begin
      if (done_o) begin
        if (span_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected result day_count %0d date_invalid %0b",
                   $time, rsp_o.day_count, rsp_o.date_invalid);
        end else begin
          want = span_q.pop_front();
          spans_checked++;
          if (want.date_invalid) invalid_seen++;
          else if (want.day_count > widest_span) widest_span = want.day_count;
          if (rsp_o.day_count !== want.day_count) begin
            mismatch_cnt++;
            $display("%0t: day_count mismatch expected %0d actual %0d",
                     $time, want.day_count, rsp_o.day_count);
          end
          if (rsp_o.date_invalid !== want.date_invalid) begin
            mismatch_cnt++;
            $display("%0t: date_invalid mismatch expected %0b actual %0b",
                     $time, want.date_invalid, rsp_o.date_invalid);
          end
        end
      end
      if (start_i && !busy_o) begin
        span_q.push_back(predict_span(req_i));
        pairs_taken++;
      end
      all_drained <= (span_q.size() == 0);

      if ((start_i && !busy_o) || done_o) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: fill the pair queue, reset, wait for completion, report
  // ---------------------------------------------------------------------------
  initial begin
    logic [DayW-1:0]   d1, d2;
    logic [MonthW-1:0] m1, m2;
    logic [YearW-1:0]  y1, y2;
    bit                no_idle;

    mismatch_cnt  = 0;
    pairs_taken   = 0;
    spans_checked = 0;
    invalid_seen  = 0;
    widest_span   = 0;

    // Directed: range extremes, leap rules, each kind of invalid date.
    queue_pair(make_pair(15, 10, 1582, 15, 10, 1582), 0, 0);  // equal dates
    queue_pair(make_pair(1, 1, 1582, 31, 12, 9999), 0, 0);   // widest span
    queue_pair(make_pair(31, 12, 9999, 1, 1, 1582), 0, 0);   // same, swapped
    queue_pair(make_pair(31, 12, 9999, 31, 12, 9999), 2, 0);
    queue_pair(make_pair(29, 2, 2000, 1, 3, 2000), 0, 0);    // leap by 400
    queue_pair(make_pair(29, 2, 1900, 1, 1, 1900), 0, 0);    // century, not leap
    queue_pair(make_pair(29, 2, 2024, 28, 2, 2023), 0, 0);
    queue_pair(make_pair(1, 1, 2000, 29, 2, 2023), 1, 0);    // second date bad
    queue_pair(make_pair(30, 2, 2024, 1, 1, 2024), 0, 0);
    queue_pair(make_pair(1, 3, 1600, 28, 2, 1600), 0, 0);
    queue_pair(make_pair(31, 12, 2000, 1, 1, 2001), 0, 0);
    queue_pair(make_pair(0, 5, 2000, 1, 5, 2000), 0, 0);     // day zero
    queue_pair(make_pair(31, 4, 2000, 1, 5, 2000), 0, 0);    // past month end
    queue_pair(make_pair(1, 6, 2000, 31, 6, 2000), 3, 0);
    queue_pair(make_pair(1, 0, 2000, 1, 1, 2000), 0, 0);     // month zero
    queue_pair(make_pair(1, 13, 2000, 1, 1, 2000), 0, 0);    // month past December
    queue_pair(make_pair(31, 15, 16383, 31, 15, 16383), 0, 0);
    queue_pair(make_pair(0, 0, 0, 0, 0, 0), 0, 0);
    queue_pair(make_pair(1, 1, 1581, 1, 1, 1582), 0, 0);     // year below range
    queue_pair(make_pair(1, 1, 2000, 1, 1, 10000), 0, 0);    // year above range
    queue_pair(make_pair(31, 12, 9999, 31, 12, 16383), 0, 0);

    // Random pairs in chunks; some chunks run back to back, drains interleaved.
    no_idle = 1'b0;
    for (int unsigned i = 0; i < RandomPairs; i++) begin
      if (i % 80 == 0) no_idle = ($urandom_range(0, 3) == 0);
      make_date(d1, m1, y1);
      make_date(d2, m2, y2);
      if ($urandom_range(0, 31) == 0) begin
        d2 = d1;
        m2 = m1;
        y2 = y1;
      end
      queue_pair(make_pair(d1, m1, y1, d2, m2, y2), pick_gap(no_idle), (i % 250 == 0));
    end

    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pair_q.size() != 0 || staged || start_i || !all_drained) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (span_q.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, span_q.size());
    $display("Ran %0d date pairs and checked %0d results: %0d invalid, widest span %0d days.",
             pairs_taken, spans_checked, invalid_seen, widest_span);
    if (mismatch_cnt == 0 && span_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
